/* rtl/core/mfc_pkg.sv */
// shared types and constants for the minifloat converter
package mfc_pkg;
  localparam int unsigned ExpMin = 2;
  localparam int unsigned ExpMax = 10;
  localparam int unsigned ManMin = 1;
  localparam int unsigned ManMax = 52;
  localparam logic [3:0] ExpReset = 4'd8;
  localparam logic [5:0] ManReset = 6'd23;
  localparam logic CfgIdxExp = 1'b0;
  localparam logic CfgIdxMan = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] operand;
  } req_t;

  typedef struct packed {
    logic [63:0] converted;
    logic        input_error;
  } rsp_t;

  typedef struct packed {
    logic [3:0] e;
    logic [5:0] m;
  } fmt_t;
endpackage

/* rtl/core/minifloat_binary64_converter.sv */
// top level of the minifloat to binary64 converter
// the result strobe rises in the cycle after start is accepted
// throughput: one conversion per cycle, busy is always low
// the result register holds one transaction; the receiver cannot stall
// reset clears the strobe and sets the format registers to e 8, m 23
module minifloat_binary64_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mfc_pkg::req_t req_i,
  output logic          done,
  output mfc_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [5:0]    cfg_data_i
);
  mfc_pkg::fmt_t fmt_q;
  mfc_pkg::rsp_t rsp_d, rsp_q;
  logic done_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  mfc_datapath u_dp (.req_i(req_i), .fmt_i(fmt_q), .rsp_o(rsp_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q.e <= mfc_pkg::ExpReset;
      fmt_q.m <= mfc_pkg::ManReset;
      done_q  <= 1'b0;
    end else begin
      done_q <= start;
      if (cfg_valid_i) begin
        if (cfg_index_i == mfc_pkg::CfgIdxExp) fmt_q.e <= cfg_data_i[3:0];
        else fmt_q.m <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) rsp_q <= rsp_d;
  end

  assign done  = done_q;
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> done)
    else $error("missing result strobe");
  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni) !start |=> !done)
    else $error("spurious result strobe");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && rsp_o.input_error |-> rsp_o.converted == 64'd0)
    else $error("error result not zero");
`endif
endmodule

/* rtl/core/mfc_lzc.sv */
// leading-one position of a 53-bit significand
module mfc_lzc (
  input  logic [52:0] sig_i,
  output logic [5:0]  pos_o
);
  always_comb begin
    pos_o = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (sig_i[i]) pos_o = 6'(i);
    end
  end
endmodule

/* rtl/core/mfc_datapath.sv */
// combinational encode and decode between binary64 and the custom format
module mfc_datapath (
  input  mfc_pkg::req_t req_i,
  input  mfc_pkg::fmt_t fmt_i,
  output mfc_pkg::rsp_t rsp_o
);
  logic [3:0]  e;
  logic [5:0]  m;
  logic [63:0] x;
  logic [10:0] ef;
  logic [52:0] sig;
  logic [5:0]  t;
  logic signed [12:0] scale, p, lim;
  logic [63:0] mant, enc, dec, body, bias, expo, mmask, emmask;
  logic [5:0]  keep;
  logic [6:0]  em;

  always_comb begin
    e = (fmt_i.e < 4'(mfc_pkg::ExpMin)) ? 4'(mfc_pkg::ExpMin) :
        (fmt_i.e > 4'(mfc_pkg::ExpMax)) ? 4'(mfc_pkg::ExpMax) : fmt_i.e;
    m = (fmt_i.m < 6'(mfc_pkg::ManMin)) ? 6'(mfc_pkg::ManMin) :
        (fmt_i.m > 6'(mfc_pkg::ManMax)) ? 6'(mfc_pkg::ManMax) : fmt_i.m;
  end

  mfc_lzc u_lzc (.sig_i(sig), .pos_o(t));

  always_comb begin
    x      = req_i.operand;
    ef     = x[62:52];
    sig    = {(ef != 11'd0), x[51:0]};
    scale  = (ef == 11'd0) ? -13'sd1074 : $signed({2'b0, ef}) - 13'sd1075;
    p      = $signed({7'b0, t}) + scale;
    lim    = -$signed({7'b0, m}) - 13'sd1;
    em     = {3'b0, e} + {1'b0, m};
    mmask  = ~(64'hFFFF_FFFF_FFFF_FFFF << m);
    emmask = ~(64'hFFFF_FFFF_FFFF_FFFF << em);
    bias   = (64'd1 << (e - 4'd1)) - 64'd1;
    // bits below the leading one, left aligned to m bits
    mant   = ((m >= t) ? ({11'b0, sig} << (m - t)) : ({11'b0, sig} >> (t - m))) & mmask;
    // below unity only m+p+1 fraction bits survive (m+p+2 counting the hidden one)
    keep   = 6'(p + $signed({7'b0, m}));
    if (p < 0) mant = mant & ~(mmask >> (keep + 6'd1)) & mmask;
    expo   = (bias + 64'($signed(p))) & ~(64'hFFFF_FFFF_FFFF_FFFF << e);
    enc    = ({63'b0, x[63]} << em) | (expo << m) | mant;
    if (sig == 53'd0 || p < lim) enc = 64'd0;
    body   = x & emmask;
    dec    = {x[em[5:0]], 11'(13'($signed({1'b0, body >> m})) - 13'(bias) + 13'd1023),
              52'((body & mmask) << (6'd52 - m))};
    if (body == 64'd0) dec = 64'd0;
    rsp_o.input_error = !req_i.mode && (ef == 11'h7FF);
    rsp_o.converted   = req_i.mode ? dec : (rsp_o.input_error ? 64'd0 : enc);
  end
endmodule
